// ===== rtl/cplt_pkg.sv =====
// ----------------------------------------------------------------------------
// cplt_pkg
// Shared types and constants of the convex piecewise-linear tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package cplt_pkg;

  localparam int VW    = 32;
  localparam int DEPTH = 1024;
  localparam int CW    = $clog2(DEPTH + 1);

  typedef logic signed [VW-1:0] val_t;
  typedef logic [CW-1:0]        cnt_t;

  typedef enum logic [2:0] {
    CMD_ADDCONST  = 3'd0,
    CMD_ADDINC    = 3'd1,
    CMD_ADDDEC    = 3'd2,
    CMD_ADDABS    = 3'd3,
    CMD_PREFIXMIN = 3'd4,
    CMD_SUFFIXMIN = 3'd5,
    CMD_WINDOW    = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_WINDOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_NOP  = 2'd0,
    ST_PUSH = 2'd1,
    ST_REPL = 2'd2
  } st_op_t;

  typedef struct packed {
    st_op_t op;
    val_t   value;
  } store_req_t;

endpackage
`default_nettype wire

// ===== rtl/cplt_if.sv =====
// ----------------------------------------------------------------------------
// cplt channel interfaces
// Valid/ready channels for commands, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none
interface cplt_in_if import cplt_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  val_t       value_a;
  val_t       value_b;
  modport source (output valid, output cmd, output value_a, output value_b, input ready);
  modport sink   (input valid, input cmd, input value_a, input value_b, output ready);
endinterface

interface cplt_out_if import cplt_pkg::*;;
  logic       valid;
  logic       ready;
  val_t       min_value;
  val_t       lower_bound;
  logic       lower_unbounded;
  val_t       upper_bound;
  logic       upper_unbounded;
  logic [1:0] status;
  modport source (output valid, output min_value, output lower_bound, output lower_unbounded,
                  output upper_bound, output upper_unbounded, output status, input ready);
  modport sink   (input valid, input min_value, input lower_bound, input lower_unbounded,
                  input upper_bound, input upper_unbounded, input status, output ready);
endinterface

interface cplt_cfg_if import cplt_pkg::*;;
  logic valid;
  logic ready;
  val_t start_minimum;
  modport source (output valid, output start_minimum, input ready);
  modport sink   (input valid, input start_minimum, output ready);
endinterface
`default_nettype wire

// ===== rtl/cplt_cell.sv =====
// ----------------------------------------------------------------------------
// cplt_cell
// One slot of the sorted breakpoint chain; trades values with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none
module cplt_cell import cplt_pkg::*; (
  input  wire logic       clk,
  input  wire store_req_t req,
  input  wire cnt_t       cnt,
  input  wire cnt_t       idx,
  input  wire logic       is_max,
  input  wire val_t       prev_val,
  input  wire logic       prev_bef,
  input  wire val_t       next_val,
  input  wire logic       next_bef,
  output val_t            own_val,
  output logic            own_bef
);

  val_t val_r, val_nxt;
  logic head;

  assign head    = (idx == '0);
  assign own_val = val_r;
  // occupied slot whose value sorts ahead of (or ties) the incoming value
  assign own_bef = (idx < cnt) &&
                   (is_max ? (val_r >= req.value) : (val_r <= req.value));

  always_comb begin
    val_nxt = val_r;
    case (req.op)
      ST_PUSH: begin
        if (own_bef) val_nxt = val_r;
        else if (prev_bef) val_nxt = req.value;
        else val_nxt = prev_val;
      end
      ST_REPL: begin
        // head leaves, remaining entries move up around the new value
        if (next_bef) val_nxt = next_val;
        else if (head || own_bef) val_nxt = req.value;
        else val_nxt = val_r;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/cplt_store.sv =====
// ----------------------------------------------------------------------------
// cplt_store
// Sorted chain of cells acting as a priority queue; head is the top entry.
// ----------------------------------------------------------------------------
`default_nettype none
module cplt_store import cplt_pkg::*; (
  input  wire logic       clk,
  input  wire store_req_t req,
  input  wire cnt_t       cnt,
  input  wire logic       is_max,
  output val_t            top
);

  val_t vals [DEPTH];
  logic befs [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      val_t pv, nv;
      logic pb, nb;
      if (i == 0) begin : g_first
        assign pv = '0;
        assign pb = 1'b1;
      end else begin : g_mid
        assign pv = vals[i-1];
        assign pb = befs[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign nv = '0;
        assign nb = 1'b0;
      end else begin : g_more
        assign nv = vals[i+1];
        assign nb = befs[i+1];
      end
      cplt_cell u_cell (
        .clk      (clk),
        .req      (req),
        .cnt      (cnt),
        .idx      (CW'(i)),
        .is_max   (is_max),
        .prev_val (pv),
        .prev_bef (pb),
        .next_val (nv),
        .next_bef (nb),
        .own_val  (vals[i]),
        .own_bef  (befs[i])
      );
    end
  endgenerate

  assign top = vals[0];

endmodule
`default_nettype wire

// ===== rtl/convex_piecewise_linear_tracker.sv =====
// ----------------------------------------------------------------------------
// convex_piecewise_linear_tracker
// Slope-trick engine: minimum, two breakpoint queues with lazy offsets.
// ----------------------------------------------------------------------------
// in_ch carries one command beat (cmd, value_a, value_b); out_ch returns one
// result beat per command with the minimum, the argmin interval and status.
// cfg_ch writes start_minimum at any time the block is idle; it is always ready.
// Breakpoints live in two chains of cells (left descending, right ascending),
// each cell swapping with its neighbors so that all cells settle an insert or
// head replace together as they register. After the accepting cycle a command
// passes S_EXEC, then S_INC and/or S_DEC for its queue updates, then S_RESP:
// constant, clip, window, clear and refused commands go straight from S_EXEC
// to S_RESP, a one-sided add passes through S_INC or S_DEC and an
// absolute-value add through S_INC and S_DEC. One command is in flight at a
// time; in_ch is ready only when the engine is idle.
// When out_ch stalls, the finished result holds in the output register and the
// next command can still be accepted and worked up to its own result cycle.
// Reset clears minimum, offsets, counts and start_minimum; queue contents need
// no clearing, since only entries below a count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none
module convex_piecewise_linear_tracker import cplt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cplt_in_if.sink   in_ch,
  cplt_out_if.source out_ch,
  cplt_cfg_if.sink  cfg_ch
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_INC, S_DEC, S_RESP} state_t;

  state_t     state_r, state_nxt;
  cmd_t       cmd_r;
  val_t       a_r, b_r;
  val_t       start_r, start_nxt;
  val_t       min_r, min_nxt;
  val_t       loff_r, loff_nxt;
  val_t       roff_r, roff_nxt;
  cnt_t       lcnt_r, lcnt_nxt;
  cnt_t       rcnt_r, rcnt_nxt;
  status_t    stat_r, stat_nxt;
  logic       ov_r, ov_nxt;
  store_req_t lreq, rreq;
  val_t       ltop, rtop;
  val_t       s_l, s_r, d_l, d_r;
  logic       lfull, rfull;

  cplt_store u_left  (.clk(clk), .req(lreq), .cnt(lcnt_r), .is_max(1'b1), .top(ltop));
  cplt_store u_right (.clk(clk), .req(rreq), .cnt(rcnt_r), .is_max(1'b0), .top(rtop));

  assign lfull = (lcnt_r == CW'(DEPTH));
  assign rfull = (rcnt_r == CW'(DEPTH));
  assign s_l   = a_r - loff_r;
  assign s_r   = a_r - roff_r;
  assign d_l   = ltop + loff_r - a_r;
  assign d_r   = a_r - (rtop + roff_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    start_nxt = (cfg_ch.valid) ? cfg_ch.start_minimum : start_r;
    min_nxt   = min_r;
    loff_nxt  = loff_r;
    roff_nxt  = roff_r;
    lcnt_nxt  = lcnt_r;
    rcnt_nxt  = rcnt_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r & ~out_ch.ready;
    lreq      = '{op: ST_NOP, value: '0};
    rreq      = '{op: ST_NOP, value: '0};
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        stat_nxt  = STAT_OK;
        state_nxt = S_RESP;
        case (cmd_r)
          CMD_ADDCONST: min_nxt = min_r + a_r;
          CMD_ADDINC: begin
            if (rfull) stat_nxt = STAT_FULL;
            else state_nxt = S_INC;
          end
          CMD_ADDDEC: begin
            if (lfull) stat_nxt = STAT_FULL;
            else state_nxt = S_DEC;
          end
          CMD_ADDABS: begin
            if (lfull || rfull) stat_nxt = STAT_FULL;
            else state_nxt = S_INC;
          end
          CMD_PREFIXMIN: rcnt_nxt = '0;
          CMD_SUFFIXMIN: lcnt_nxt = '0;
          CMD_WINDOW: begin
            if (a_r > b_r) stat_nxt = STAT_WINDOW;
            else begin
              loff_nxt = loff_r + a_r;
              roff_nxt = roff_r + b_r;
            end
          end
          default: begin
            min_nxt  = start_r;
            lcnt_nxt = '0;
            rcnt_nxt = '0;
            loff_nxt = '0;
            roff_nxt = '0;
          end
        endcase
      end
      S_INC: begin
        rreq.op    = ST_PUSH;
        rreq.value = a_r - roff_r;
        if (lcnt_r != '0) begin
          if (d_l != '0 && !d_l[VW-1]) min_nxt = min_r + d_l;
          if (ltop > s_l) begin
            lreq.op    = ST_REPL;
            lreq.value = s_l;
            rreq.value = ltop + loff_r - roff_r;
          end
        end
        rcnt_nxt  = rcnt_r + 1'b1;
        state_nxt = (cmd_r == CMD_ADDABS) ? S_DEC : S_RESP;
      end
      S_DEC: begin
        lreq.op    = ST_PUSH;
        lreq.value = a_r - loff_r;
        if (rcnt_r != '0) begin
          if (d_r != '0 && !d_r[VW-1]) min_nxt = min_r + d_r;
          if (rtop < s_r) begin
            rreq.op    = ST_REPL;
            rreq.value = s_r;
            lreq.value = rtop + roff_r - loff_r;
          end
        end
        lcnt_nxt  = lcnt_r + 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= '0;
      min_r   <= '0;
      loff_r  <= '0;
      roff_r  <= '0;
      lcnt_r  <= '0;
      rcnt_r  <= '0;
      ov_r    <= 1'b0;
      stat_r  <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      min_r   <= min_nxt;
      loff_r  <= loff_nxt;
      roff_r  <= roff_nxt;
      lcnt_r  <= lcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      ov_r    <= ov_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // command latch and result register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r <= cmd_t'(in_ch.cmd);
      a_r   <= in_ch.value_a;
      b_r   <= in_ch.value_b;
    end
    if (state_r == S_RESP && (!ov_r || out_ch.ready)) begin
      out_ch.min_value       <= min_r;
      out_ch.lower_bound     <= (lcnt_r != '0) ? ltop + loff_r : '0;
      out_ch.lower_unbounded <= (lcnt_r == '0);
      out_ch.upper_bound     <= (rcnt_r != '0) ? rtop + roff_r : '0;
      out_ch.upper_unbounded <= (rcnt_r == '0);
      out_ch.status          <= stat_r;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_convex_piecewise_linear_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_convex_piecewise_linear_tracker
// Drives command beats with random gaps and output stalls, predicts every
// result with a behavioral slope-trick model and compares field by field.
// ----------------------------------------------------------------------------
module tb_convex_piecewise_linear_tracker;
  import cplt_pkg::*;

  typedef struct packed {
    val_t       min_value;
    val_t       lower_bound;
    logic       lower_unbounded;
    val_t       upper_bound;
    logic       upper_unbounded;
    logic [1:0] status;
  } summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  cplt_in_if  in_ch ();
  cplt_out_if out_ch ();
  cplt_cfg_if cfg_ch ();

  convex_piecewise_linear_tracker dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  val_t     pred_start, pred_min, pred_loff, pred_roff;
  val_t     lheap [DEPTH];
  val_t     rheap [DEPTH];
  int       lcnt, rcnt;
  summary_t summary_q [$];
  bit       failed = 0;
  int       cycles = 0;
  int       abs_pref = 0;

  function automatic bit heap_above(val_t x, val_t y, bit maxh);
    return maxh ? (x > y) : (x < y);
  endfunction

  task automatic heap_push(bit maxh, val_t v);
    int i, p;
    val_t t;
    if (maxh) begin
      i = lcnt; lheap[i] = v; lcnt++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!heap_above(lheap[i], lheap[p], 1)) break;
        t = lheap[i]; lheap[i] = lheap[p]; lheap[p] = t; i = p;
      end
    end else begin
      i = rcnt; rheap[i] = v; rcnt++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!heap_above(rheap[i], rheap[p], 0)) break;
        t = rheap[i]; rheap[i] = rheap[p]; rheap[p] = t; i = p;
      end
    end
  endtask

  task automatic heap_replace_top(bit maxh, val_t v);
    int i, l, r, b, n;
    val_t t;
    i = 0;
    n = maxh ? lcnt : rcnt;
    if (maxh) lheap[0] = v; else rheap[0] = v;
    forever begin
      l = 2 * i + 1; r = l + 1; b = i;
      if (maxh) begin
        if (l < n && heap_above(lheap[l], lheap[b], 1)) b = l;
        if (r < n && heap_above(lheap[r], lheap[b], 1)) b = r;
        if (b == i) break;
        t = lheap[i]; lheap[i] = lheap[b]; lheap[b] = t;
      end else begin
        if (l < n && heap_above(rheap[l], rheap[b], 0)) b = l;
        if (r < n && heap_above(rheap[r], rheap[b], 0)) b = r;
        if (b == i) break;
        t = rheap[i]; rheap[i] = rheap[b]; rheap[b] = t;
      end
      i = b;
    end
  endtask

  task automatic add_rising(val_t a);
    val_t s, moved, d;
    s = a - pred_loff;
    moved = a;
    if (lcnt > 0) begin
      d = lheap[0] + pred_loff - a;
      if (d > 0) pred_min = pred_min + d;
      if (lheap[0] > s) begin
        moved = lheap[0] + pred_loff;
        heap_replace_top(1, s);
      end
    end
    heap_push(0, moved - pred_roff);
  endtask

  task automatic add_falling(val_t a);
    val_t s, moved, d;
    s = a - pred_roff;
    moved = a;
    if (rcnt > 0) begin
      d = a - (rheap[0] + pred_roff);
      if (d > 0) pred_min = pred_min + d;
      if (rheap[0] < s) begin
        moved = rheap[0] + pred_roff;
        heap_replace_top(0, s);
      end
    end
    heap_push(1, moved - pred_loff);
  endtask

  task automatic apply_command(cmd_t c, val_t a, val_t b);
    summary_t r;
    logic [1:0] st;
    st = STAT_OK;
    case (c)
      CMD_ADDCONST: pred_min = pred_min + a;
      CMD_ADDINC: if (rcnt >= DEPTH) st = STAT_FULL; else add_rising(a);
      CMD_ADDDEC: if (lcnt >= DEPTH) st = STAT_FULL; else add_falling(a);
      CMD_ADDABS: begin
        if (lcnt >= DEPTH || rcnt >= DEPTH) st = STAT_FULL;
        else begin
          add_rising(a);
          add_falling(a);
        end
      end
      CMD_PREFIXMIN: rcnt = 0;
      CMD_SUFFIXMIN: lcnt = 0;
      CMD_WINDOW: begin
        if (a > b) st = STAT_WINDOW;
        else begin
          pred_loff = pred_loff + a;
          pred_roff = pred_roff + b;
        end
      end
      default: begin
        pred_min = pred_start;
        lcnt = 0; rcnt = 0; pred_loff = 0; pred_roff = 0;
      end
    endcase
    r.min_value = pred_min;
    r.lower_unbounded = (lcnt == 0);
    r.lower_bound = (lcnt > 0) ? lheap[0] + pred_loff : '0;
    r.upper_unbounded = (rcnt == 0);
    r.upper_bound = (rcnt > 0) ? rheap[0] + pred_roff : '0;
    r.status = st;
    summary_q.push_back(r);
  endtask

  // ---- driving
  initial begin
    in_ch.valid = 0; in_ch.cmd = '0; in_ch.value_a = '0; in_ch.value_b = '0;
    cfg_ch.valid = 0; cfg_ch.start_minimum = '0;
    out_ch.ready = 0;
  end

  // valid stays high after an accepted beat until the next gap or idle call;
  // the engine is busy after each accepted beat
  task automatic send_cmd(cmd_t c, val_t a, val_t b);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.cmd <= c; in_ch.value_a <= a; in_ch.value_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_command(c, a, b);
    @(negedge clk);
  endtask

  task automatic write_start(val_t v);
    in_ch.valid <= 0;
    wait (summary_q.size() == 0);
    repeat (10) @(negedge clk);
    cfg_ch.valid <= 1; cfg_ch.start_minimum <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    pred_start = v;
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic val_t rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $urandom;
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // ---- result stall and checking
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(0, 10) < 7) ? 1'b1 : 1'b0;
  end

  always @(posedge clk) begin
    summary_t e;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (summary_q.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1;
      end else begin
        e = summary_q.pop_front();
        if (out_ch.min_value !== e.min_value) begin
          $error("min_value exp %0d got %0d", e.min_value, out_ch.min_value); failed = 1;
        end
        if (out_ch.lower_bound !== e.lower_bound) begin
          $error("lower_bound exp %0d got %0d", e.lower_bound, out_ch.lower_bound);
          failed = 1;
        end
        if (out_ch.lower_unbounded !== e.lower_unbounded) begin
          $error("lower_unbounded exp %0d got %0d", e.lower_unbounded,
                 out_ch.lower_unbounded);
          failed = 1;
        end
        if (out_ch.upper_bound !== e.upper_bound) begin
          $error("upper_bound exp %0d got %0d", e.upper_bound, out_ch.upper_bound);
          failed = 1;
        end
        if (out_ch.upper_unbounded !== e.upper_unbounded) begin
          $error("upper_unbounded exp %0d got %0d", e.upper_unbounded,
                 out_ch.upper_unbounded);
          failed = 1;
        end
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status); failed = 1;
        end
      end
    end
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---- tests
  task automatic test_directed();
    send_cmd(CMD_ADDINC, 5, 0);
    send_cmd(CMD_ADDDEC, 5, 0);
    send_cmd(CMD_ADDABS, 5, 0);
    send_cmd(CMD_ADDABS, 32'sh7fffffff, 0);
    send_cmd(CMD_ADDABS, 32'sh80000000, 0);
    send_cmd(CMD_ADDCONST, 32'sh7fffffff, 0);
    send_cmd(CMD_ADDCONST, -1, 0);
    send_cmd(CMD_WINDOW, -3, 7);
    send_cmd(CMD_WINDOW, 7, -3);
    send_cmd(CMD_WINDOW, 32'sh80000000, 32'sh7fffffff);
    send_cmd(CMD_WINDOW, 4, 4);
    send_cmd(CMD_ADDINC, 0, 0);
    send_cmd(CMD_ADDDEC, 32'sh7fffffff, 0);
    send_cmd(CMD_PREFIXMIN, 0, 0);
    send_cmd(CMD_SUFFIXMIN, 0, 0);
    send_cmd(CMD_ADDDEC, -9, 0);
    send_cmd(CMD_CLEAR, 0, 0);
  endtask

  // fills both stores to the brim and tries one more insert on each side
  task automatic test_full_store();
    repeat (DEPTH) send_cmd(CMD_ADDABS, $signed($urandom_range(0, 64)) - 32, 0);
    send_cmd(CMD_ADDABS, 1, 0);
    send_cmd(CMD_ADDINC, 1, 0);
    send_cmd(CMD_ADDDEC, 1, 0);
    send_cmd(CMD_PREFIXMIN, 0, 0);
    send_cmd(CMD_ADDINC, 2, 0);
    send_cmd(CMD_ADDABS, 2, 0);
    send_cmd(CMD_CLEAR, 0, 0);
  endtask

  task automatic test_random(int n);
    int k;
    cmd_t c;
    val_t a, b;
    for (k = 0; k < n; k++) begin
      k = k;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: c = CMD_ADDINC;
        4, 5, 6, 7: c = CMD_ADDDEC;
        8, 9, 10, 11: c = CMD_ADDABS;
        12, 13: c = CMD_ADDCONST;
        14, 15, 16: c = CMD_WINDOW;
        17: c = CMD_PREFIXMIN;
        18: c = CMD_SUFFIXMIN;
        default: c = CMD_CLEAR;
      endcase
      a = rand_value();
      b = rand_value();
      if (c == CMD_WINDOW && $urandom_range(0, 3) != 0 && a > b) begin
        a = b; b = rand_value();
        if (a > b) b = a;
      end
      send_cmd(c, a, b);
    end
  endtask

  initial begin
    pred_start = 0; pred_min = 0; pred_loff = 0; pred_roff = 0; lcnt = 0; rcnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed();
    write_start(32'sh7fffffff);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_ADDCONST, 1, 0);
    write_start(32'sh80000000);
    send_cmd(CMD_CLEAR, 0, 0);
    test_full_store();
    write_start(-12345);
    test_random(270);
    write_start($urandom);
    test_random(270);
    in_ch.valid <= 0;
    wait (summary_q.size() == 0);
    repeat (20) @(posedge clk);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
